// File: src/tpc_pkg.sv
// tpc_pkg: shared constants for the trie prefix counter
// field widths, request mode codes and default sizes; no dependencies

package tpc_pkg;

  localparam int MODE_W    = 2;
  localparam int LETTER_W  = 5;
  localparam int PCOUNT_W  = 16;

  localparam int NODE_POOL_DEF  = 4096;
  localparam int ALPHABET_DEF   = 26;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

endpackage

// File: src/tpc_req_if.sv
// tpc_req_if: valid/ready request channel carrying one letter of a word
// depends on tpc_pkg for the field widths

interface tpc_req_if
  import tpc_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [LETTER_W-1:0] letter;
  logic                last;

  modport source (output valid, output mode, output letter, output last, input ready);
  modport sink   (input valid, input mode, input letter, input last, output ready);
endinterface

// File: src/tpc_rsp_if.sv
// tpc_rsp_if: valid/ready response channel carrying one prefix count
// depends on tpc_pkg for the field widths

interface tpc_rsp_if
  import tpc_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [PCOUNT_W-1:0] prefix_count;
  logic                pool_full;

  modport source (output valid, output prefix_count, output pool_full, input ready);
  modport sink   (input valid, input prefix_count, input pool_full, output ready);
endinterface

// File: src/trie_prefix_counter_core.sv
// trie_prefix_counter_core: prefix-counting trie with a fixed node pool
// depends on tpc_pkg, tpc_req_if and tpc_rsp_if
//
// usage:
//   req carries one letter per request: mode (insert, search, clear), letter
//   index and a last mark. rsp carries one response per word, on its last
//   letter: the count of inserted words sharing the prefix (0 if the path is
//   absent or the word was dropped) and the sticky pool_full flag.
// steps:
//   an insert or search letter passes the request state, the child table
//   read and the node table read and write back. the last letter of a word
//   adds a state to load the response register. a clear, an unused mode or
//   a letter of a dropped word ends in the request state; a dropped last
//   letter adds the load. two dependent registered memory reads per letter
//   set the steps: child pointer, then that node's parent tag and count.
// reset and clear:
//   rst (synchronous) and a clear request empty the trie at once: only the
//   node fill count goes back to one. a child pointer is trusted only if it
//   names an allocated node whose stored parent slot is this slot, so no
//   clearing pass is needed and the memories have no reset.
// stalls:
//   the response is held in an output register until taken; a last letter
//   waits for it to drain before loading, and no new request is taken then.

module trie_prefix_counter_core
  import tpc_pkg::*;
#(
  parameter int NODE_POOL  = NODE_POOL_DEF,
  parameter int ALPHABET   = ALPHABET_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tpc_req_if.sink   req,
  tpc_rsp_if.source rsp
);

  localparam int NODE_W      = $clog2(NODE_POOL);
  localparam int USED_W      = $clog2(NODE_POOL + 1);
  localparam int TABLE_DEPTH = NODE_POOL * ALPHABET;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int CMP_W       = 9;   // holds any alphabet size up to 256
  localparam int CEXT_W      = (COUNT_BITS > PCOUNT_W) ? COUNT_BITS : PCOUNT_W;
  localparam int NODE_ENT_W  = SLOT_W + COUNT_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHILD = 2'd1;
  localparam logic [1:0] ST_NODE  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // child table: one child index per (node, letter) slot, 0 means none
  logic [NODE_W-1:0]     child_mem [TABLE_DEPTH];
  // node table: parent slot tag and saturating prefix count per node
  logic [NODE_ENT_W-1:0] node_mem  [NODE_POOL];

  logic [1:0]            state, state_next;
  logic [NODE_W-1:0]     cursor, cursor_next;
  logic [USED_W-1:0]     nodes_used, nodes_used_next;
  logic                  word_failed, word_failed_next;
  logic                  overflowed, overflowed_next;
  logic [COUNT_BITS-1:0] cur_count, cur_count_next;
  logic [SLOT_W-1:0]     slot_q, slot_q_next;
  logic                  is_insert, is_insert_next;
  logic                  last_q, last_q_next;
  logic                  rsp_valid, rsp_valid_next;
  logic [PCOUNT_W-1:0]   rsp_count, rsp_count_next;
  logic                  rsp_full, rsp_full_next;

  // memory read data, registered
  logic [NODE_W-1:0]     child_rd;
  logic [NODE_ENT_W-1:0] node_rd;

  // memory controls
  logic                  child_rd_en, child_we;
  logic [SLOT_W-1:0]     child_addr;
  logic [NODE_W-1:0]     child_wdata;
  logic                  node_rd_en, node_we;
  logic [NODE_W-1:0]     node_raddr, node_waddr;
  logic [NODE_ENT_W-1:0] node_wdata;

  logic                  bad_letter;
  logic [SLOT_W-1:0]     slot_calc;
  logic [SLOT_W-1:0]     node_parent;
  logic [COUNT_BITS-1:0] node_count;
  logic [COUNT_BITS-1:0] count_bumped;
  logic                  child_ok;
  logic                  pool_exhausted;
  logic [CEXT_W-1:0]     count_ext;
  logic [PCOUNT_W-1:0]   count_clamped;

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = rsp_valid;
  assign rsp.prefix_count = rsp_count;
  assign rsp.pool_full    = rsp_full;

  // letter outside the alphabet acts as a child that can never exist
  assign bad_letter = (CMP_W'(req.letter) >= CMP_W'(ALPHABET));
  assign slot_calc  = SLOT_W'(cursor) * SLOT_W'(ALPHABET) + SLOT_W'(req.letter);

  assign node_parent = node_rd[NODE_ENT_W-1:COUNT_BITS];
  assign node_count  = node_rd[COUNT_BITS-1:0];
  assign count_bumped = (node_count == {COUNT_BITS{1'b1}}) ? node_count
                                                           : node_count + 1'b1;

  // a stored pointer is live only if it names a node of this generation that
  // was allocated for exactly this slot
  assign child_ok = (child_rd != '0)
                 && ({1'b0, child_rd} < nodes_used)
                 && (node_parent == slot_q);

  assign pool_exhausted = (nodes_used == USED_W'(NODE_POOL));

  // clamp the node count to the response field
  assign count_ext     = CEXT_W'(cur_count);
  assign count_clamped = (count_ext > CEXT_W'({PCOUNT_W{1'b1}})) ? {PCOUNT_W{1'b1}}
                                                                 : count_ext[PCOUNT_W-1:0];

  always_comb begin
    state_next       = state;
    cursor_next      = cursor;
    nodes_used_next  = nodes_used;
    word_failed_next = word_failed;
    overflowed_next  = overflowed;
    cur_count_next   = cur_count;
    slot_q_next      = slot_q;
    is_insert_next   = is_insert;
    last_q_next      = last_q;
    rsp_valid_next   = rsp_valid && !rsp.ready;
    rsp_count_next   = rsp_count;
    rsp_full_next    = rsp_full;

    child_rd_en = 1'b0;
    child_we    = 1'b0;
    child_addr  = slot_calc;
    child_wdata = nodes_used[NODE_W-1:0];
    node_rd_en  = 1'b0;
    node_raddr  = child_rd;
    node_we     = 1'b0;
    node_waddr  = child_rd;
    node_wdata  = {slot_q, count_bumped};

    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          case (req.mode)
            MODE_CLEAR: begin
              nodes_used_next  = USED_W'(1);
              cursor_next      = '0;
              word_failed_next = 1'b0;
              overflowed_next  = 1'b0;
            end
            MODE_INSERT, MODE_SEARCH: begin
              is_insert_next = (req.mode == MODE_INSERT);
              last_q_next    = req.last;
              if (word_failed || bad_letter) begin
                // dropped word: skip the walk, answer on its last letter
                word_failed_next = 1'b1;
                if (req.last) begin
                  state_next = ST_FIN;
                end
              end else begin
                child_rd_en = 1'b1;
                slot_q_next = slot_calc;
                state_next  = ST_CHILD;
              end
            end
            default: ;
          endcase
        end
      end

      ST_CHILD: begin
        node_rd_en = 1'b1;
        state_next = ST_NODE;
      end

      ST_NODE: begin
        state_next = last_q ? ST_FIN : ST_IDLE;
        if (child_ok) begin
          cursor_next = child_rd;
          if (is_insert) begin
            node_we        = 1'b1;
            cur_count_next = count_bumped;
          end else begin
            cur_count_next = node_count;
          end
        end else if (!is_insert) begin
          word_failed_next = 1'b1;
        end else if (pool_exhausted) begin
          overflowed_next  = 1'b1;
          word_failed_next = 1'b1;
        end else begin
          // allocate the next free node with a count of one
          child_we        = 1'b1;
          child_addr      = slot_q;
          node_we         = 1'b1;
          node_waddr      = nodes_used[NODE_W-1:0];
          node_wdata      = {slot_q, COUNT_BITS'(1)};
          cursor_next     = nodes_used[NODE_W-1:0];
          cur_count_next  = COUNT_BITS'(1);
          nodes_used_next = nodes_used + 1'b1;
        end
      end

      ST_FIN: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next   = 1'b1;
          rsp_count_next   = word_failed ? '0 : count_clamped;
          rsp_full_next    = overflowed;
          cursor_next      = '0;
          word_failed_next = 1'b0;
          state_next       = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cursor      <= '0;
      nodes_used  <= USED_W'(1);
      word_failed <= 1'b0;
      overflowed  <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      cursor      <= cursor_next;
      nodes_used  <= nodes_used_next;
      word_failed <= word_failed_next;
      overflowed  <= overflowed_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_count <= cur_count_next;
    slot_q    <= slot_q_next;
    is_insert <= is_insert_next;
    last_q    <= last_q_next;
    rsp_count <= rsp_count_next;
    rsp_full  <= rsp_full_next;
  end

  // child table port
  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[child_addr] <= child_wdata;
    end
    if (child_rd_en) begin
      child_rd <= child_mem[child_addr];
    end
  end

  // node table port
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_rd_en) begin
      node_rd <= node_mem[node_raddr];
    end
  end

endmodule

// File: src/tpc_checker.sv
// tpc_checker: port-level assertions for trie_prefix_counter_core
// depends on tpc_pkg; bound to trie_prefix_counter_core at the end of this file

module tpc_checker
  import tpc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic [MODE_W-1:0]   req_mode,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [PCOUNT_W-1:0] rsp_prefix_count,
  input logic                rsp_pool_full
);

  // stalled response stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // stalled response keeps its payload
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_prefix_count) && $stable(rsp_pool_full))
    else $error("response payload changed while stalled");

  // reset empties the response register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response offered right after reset");

  // a clear never produces a response
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_mode == MODE_CLEAR) && !rsp_valid |=> !rsp_valid)
    else $error("response produced by a clear");

endmodule

bind trie_prefix_counter_core tpc_checker u_tpc_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_mode         (req.mode),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_prefix_count (rsp.prefix_count),
  .rsp_pool_full    (rsp.pool_full)
);
